// File: rtl/pvle_pkg.sv
package pvle_pkg;

	// Stream payload widths
	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 184;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND   = 8'd1;

	localparam logic [31:0] MIN_GAP_RESET = 32'd5000000;
	localparam logic [16:0] BLEND_RESET   = 17'd62259;

	// Fixed-point constants
	localparam logic signed [30:0] NS_PER_S      = 31'sd1000000000;
	localparam logic signed [19:0] TWO_PI_Q16    = 20'sd411775;
	localparam logic signed [19:0] PI_Q16_FLOOR  = 20'sd205887;
	localparam logic signed [63:0] HALF_LSB_UP   = 64'sd32768;
	localparam logic signed [63:0] HALF_LSB_DOWN = 64'sd32767;

	// Divider: 33 quotient bits, one per cycle
	localparam int DIV_STEPS = 33;
	localparam int DIV_CNT_W = 6;

	typedef struct packed {
		logic        ovf;
		logic [32:0] quo;
	} pvle_div_res_t;

endpackage

// File: rtl/pvle_div.sv
module pvle_div
	import pvle_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   num,
	input  logic [62:0]   den,
	output logic          done,
	output pvle_div_res_t res
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [62:0]          rem_q;
	logic [32:0]          low_q;
	logic [32:0]          quo_q;
	logic                 ovf_q;
	logic [63:0]          trial;
	logic [63:0]          diff;
	logic                 fits;

	// Shift in the next numerator bit and try one subtract
	assign trial = {rem_q, low_q[32]};
	assign diff  = trial - {1'b0, den};
	assign fits  = trial >= {1'b0, den};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division, quotient bits from the top down
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {32'b0, num[63:33]};
			low_q <= num[32:0];
			quo_q <= '0;
			// quotient of 2^33 or more: saturate later
			ovf_q <= {33'b0, num[63:33]} >= {1'b0, den};
		end else if (busy_q) begin
			rem_q <= fits ? diff[62:0] : trial[62:0];
			low_q <= {low_q[31:0], 1'b0};
			quo_q <= {quo_q[31:0], fits};
		end
	end

	assign done    = done_q;
	assign res.ovf = ovf_q;
	assign res.quo = quo_q;

endmodule

// File: rtl/pose_velocity_lowpass_estimator_core.sv
// Channel    Direction  Handshake                   Payload
// s_axis     in         s_axis_tvalid/tready        pose and stamp
// m_axis     out        m_axis_tvalid/tready        pose and filtered rates
// cfg        in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// A pose after the first passes the gap check (ST_GAP, ST_CHK), then x, y and
// heading in turn through the 33-step shared divider, and a load of the output.
// The first pose goes straight to the output load; a dropped pose ends at the check.
// Reset clears the history, so the next pose counts as the first.
// A finished result waits in the output register; the next pose is taken
// meanwhile and holds in its final step until the output is free.
module pose_velocity_lowpass_estimator_core
	import pvle_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pose_x[31:0], pose_y[63:32], heading[82:64], stamp_ns[145:83], zeros
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_x[31:0], out_y[63:32], out_heading[82:64], vel_x[114:83],
	// vel_y[146:115], yaw_rate[178:147], zeros
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAP,
		ST_CHK,
		ST_DELTA,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_WAIT,
		ST_SAT,
		ST_DIFF,
		ST_BMUL,
		ST_BADD,
		ST_RND,
		ST_DONE
	} state_t;

	localparam logic [1:0] LANE_X = 2'd0;
	localparam logic [1:0] LANE_Y = 2'd1;
	localparam logic [1:0] LANE_H = 2'd2;

	state_t state_q;
	logic [1:0] lane_q;
	logic primed_q;
	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Configuration
	logic [31:0] min_gap_q;
	logic [16:0] blend_q;

	// History
	logic signed [31:0] last_x_q;
	logic signed [31:0] last_y_q;
	logic signed [18:0] last_h_q;
	logic signed [31:0] last_vx_q;
	logic signed [31:0] last_vy_q;
	logic signed [31:0] last_wz_q;
	logic [62:0] last_stamp_q;

	// Current pose
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic signed [18:0] ph_q;
	logic [62:0] st_q;

	// Working registers
	logic [62:0] gap_q;
	logic borrow_q;
	logic neg_q;
	logic [32:0] mag_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] num_q;
	logic signed [31:0] raw_q;
	logic signed [32:0] diff_q;
	logic signed [31:0] vx_q;
	logic signed [31:0] vy_q;
	logic signed [31:0] wz_q;

	logic in_accept;
	logic [63:0] gap_full;
	logic [31:0] min_eff;
	logic signed [19:0] dh_raw;
	logic signed [19:0] dh_wrap;
	logic signed [32:0] delta;
	logic signed [31:0] prev_vel;
	logic [15:0] a_eff;
	logic signed [33:0] mul_a;
	logic signed [30:0] mul_b;
	logic signed [64:0] mul_p;
	logic signed [63:0] add_b;
	logic signed [63:0] add_sum;
	logic signed [63:0] rnd;
	logic signed [31:0] sat_val;
	logic div_start;
	logic div_done;
	pvle_div_res_t div_res;

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign div_start     = (state_q == ST_DIV);

	// Gap against the last stamp kept in the history, with borrow for backward stamps
	assign gap_full = {1'b0, st_q} - {1'b0, last_stamp_q};
	assign min_eff  = (min_gap_q == 32'd0) ? 32'd1 : min_gap_q;

	// Heading delta, wrapped into [-pi, pi]
	assign dh_raw = {ph_q[18], ph_q} - {last_h_q[18], last_h_q};
	always_comb begin
		dh_wrap = dh_raw;
		if (dh_raw > PI_Q16_FLOOR) begin
			dh_wrap = dh_raw - TWO_PI_Q16;
		end else if (dh_raw < -PI_Q16_FLOOR) begin
			dh_wrap = dh_raw + TWO_PI_Q16;
		end
	end

	// Select the lane's delta and previous rate
	always_comb begin
		case (lane_q)
			LANE_X: begin
				delta    = {px_q[31], px_q} - {last_x_q[31], last_x_q};
				prev_vel = last_vx_q;
			end
			LANE_Y: begin
				delta    = {py_q[31], py_q} - {last_y_q[31], last_y_q};
				prev_vel = last_vy_q;
			end
			default: begin
				delta    = {{13{dh_wrap[19]}}, dh_wrap};
				prev_vel = last_wz_q;
			end
		endcase
	end

	// Coefficient at or above one disables the blend
	assign a_eff = blend_q[16] ? 16'd0 : blend_q[15:0];

	// Shared multiplier: |delta| * 1e9, or a * (prev - raw)
	always_comb begin
		if (state_q == ST_BMUL) begin
			mul_a = {diff_q[32], diff_q};
			mul_b = {15'b0, a_eff};
		end else begin
			mul_a = {1'b0, mag_q};
			mul_b = NS_PER_S;
		end
	end
	assign mul_p = mul_a * mul_b;

	// Shared adder: add half the gap for rounding, or raw * 65536 for the blend
	assign add_b   = (state_q == ST_ADD) ? {2'b0, gap_q[62:1]}
	                                     : {{16{raw_q[31]}}, raw_q, 16'b0};
	assign add_sum = prod_q + add_b;

	// Round half away from zero on the divide by 65536
	assign rnd = num_q + (num_q[63] ? HALF_LSB_DOWN : HALF_LSB_UP);

	// Saturate the signed quotient to 32 bits
	always_comb begin
		if (neg_q) begin
			if (div_res.ovf || div_res.quo[32:31] != 2'b00) begin
				sat_val = 32'sh8000_0000;
			end else begin
				sat_val = -$signed(div_res.quo[31:0]);
			end
		end else begin
			if (div_res.ovf || div_res.quo[32:31] != 2'b00) begin
				sat_val = 32'sh7FFF_FFFF;
			end else begin
				sat_val = $signed(div_res.quo[31:0]);
			end
		end
	end

	pvle_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (gap_q),
		.done   (div_done),
		.res    (div_res)
	);

	// Sequencer, history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			lane_q       <= LANE_X;
			primed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			min_gap_q    <= MIN_GAP_RESET;
			blend_q      <= BLEND_RESET;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_h_q     <= '0;
			last_vx_q    <= '0;
			last_vy_q    <= '0;
			last_wz_q    <= '0;
			last_stamp_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MIN_GAP) begin
					min_gap_q <= cfg_data;
				end else if (cfg_index == REG_BLEND) begin
					blend_q <= cfg_data[16:0];
				end
			end
			// release a taken result unless a new one is loaded below
			if (out_valid_q && m_axis_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= primed_q ? ST_GAP : ST_DONE;
					end
				end
				ST_GAP: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// drop close or backward stamps without touching the history
					if (borrow_q || gap_q < {31'b0, min_eff}) begin
						state_q <= ST_IDLE;
					end else begin
						lane_q  <= LANE_X;
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_ADD;
				ST_ADD:   state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_BMUL;
				ST_BMUL: state_q <= ST_BADD;
				ST_BADD: state_q <= ST_RND;
				ST_RND: begin
					if (lane_q == LANE_H) begin
						state_q <= ST_DONE;
					end else begin
						lane_q  <= lane_q + 1'b1;
						state_q <= ST_DELTA;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						primed_q     <= 1'b1;
						last_x_q     <= px_q;
						last_y_q     <= py_q;
						last_h_q     <= ph_q;
						last_vx_q    <= vx_q;
						last_vy_q    <= vy_q;
						last_wz_q    <= wz_q;
						last_stamp_q <= st_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_q <= s_axis_tdata[31:0];
			py_q <= s_axis_tdata[63:32];
			ph_q <= s_axis_tdata[82:64];
			st_q <= s_axis_tdata[145:83];
			vx_q <= '0;
			vy_q <= '0;
			wz_q <= '0;
		end
		case (state_q)
			ST_GAP: begin
				gap_q    <= gap_full[62:0];
				borrow_q <= gap_full[63];
			end
			ST_DELTA: begin
				neg_q <= delta[32];
				mag_q <= delta[32] ? 33'(-delta) : 33'(delta);
			end
			ST_MUL:  prod_q <= mul_p[63:0];
			ST_ADD:  num_q  <= add_sum;
			ST_SAT:  raw_q  <= sat_val;
			ST_DIFF: diff_q <= {prev_vel[31], prev_vel} - {raw_q[31], raw_q};
			ST_BMUL: prod_q <= mul_p[63:0];
			ST_BADD: num_q  <= add_sum;
			ST_RND: begin
				case (lane_q)
					LANE_X:  vx_q <= rnd[47:16];
					LANE_Y:  vy_q <= rnd[47:16];
					default: wz_q <= rnd[47:16];
				endcase
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_data_q <= {5'b0, wz_q, vy_q, vx_q, ph_q, py_q, px_q};
				end
			end
			default: ;
		endcase
	end

endmodule

// File: bench/tb_pose_velocity_lowpass_estimator_core.sv
`timescale 1ns / 100ps

// One pose estimate as it leaves the block
typedef struct {
	logic [31:0] x;
	logic [31:0] y;
	logic [18:0] heading;
	logic [31:0] vel_x;
	logic [31:0] vel_y;
	logic [31:0] yaw_rate;
} pose_estimate_t;

// Tracks pose history and filtered rates, holds the estimates still owed
class pose_rate_tracker;
	localparam longint UNITY      = 65536;
	localparam longint HALF_UNITY = 32768;
	localparam longint FULL_TURN  = 411775;
	localparam longint HALF_TURN  = 205887;

	int unsigned     min_gap;
	logic [16:0]     blend;
	int              last_x;
	int              last_y;
	int              last_heading;
	int              last_vel_x;
	int              last_vel_y;
	int              last_yaw_rate;
	longint unsigned last_stamp;
	bit              primed;
	int              mismatches;
	pose_estimate_t  pending_estimates[$];

	function new();
		min_gap       = pvle_pkg::MIN_GAP_RESET;
		blend         = pvle_pkg::BLEND_RESET;
		last_x        = 0;
		last_y        = 0;
		last_heading  = 0;
		last_vel_x    = 0;
		last_vel_y    = 0;
		last_yaw_rate = 0;
		last_stamp    = 0;
		primed        = 1'b0;
		mismatches    = 0;
	endfunction

	function void set_reg(logic [pvle_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		if (idx == pvle_pkg::REG_MIN_GAP) begin
			min_gap = val;
		end else if (idx == pvle_pkg::REG_BLEND) begin
			blend = val[16:0];
		end
	endfunction

	// delta per second over gap ns, rounded half away from zero, saturated
	function int finite_rate(longint delta, longint unsigned gap);
		longint unsigned mag;
		longint unsigned q;
		mag = (delta < 0) ? -delta : delta;
		q = (mag * 64'd1000000000 + gap / 64'd2) / gap;
		if (delta < 0) begin
			if (q >= 64'd2147483648)
				return 32'h80000000;
			return -int'(q);
		end
		if (q > 64'd2147483647)
			return 32'h7FFFFFFF;
		return int'(q);
	endfunction

	// first-order lowpass in Q0.16, rounded half away from zero
	function int lowpass_mix(int prev, int raw, longint a);
		longint num;
		num = a * longint'(prev) + (UNITY - a) * longint'(raw);
		if (num >= 0)
			return int'((num + HALF_UNITY) / UNITY);
		return int'(-((-num + HALF_UNITY) / UNITY));
	endfunction

	// advance the history on an accepted pose, owe an estimate unless dropped
	function void take_pose(logic signed [31:0] px, logic signed [31:0] py,
		logic signed [18:0] ph, logic [62:0] st);
		longint unsigned eff_gap;
		longint unsigned gap;
		longint          dh;
		longint          a;
		int              vx;
		int              vy;
		int              wz;
		pose_estimate_t  est;
		vx = 0;
		vy = 0;
		wz = 0;
		if (primed) begin
			eff_gap = (min_gap == 0) ? 64'd1 : 64'(min_gap);
			if (64'(st) < last_stamp)
				return;
			gap = 64'(st) - last_stamp;
			if (gap < eff_gap)
				return;
			dh = longint'(ph) - longint'(last_heading);
			if (dh > HALF_TURN)
				dh -= FULL_TURN;
			else if (dh < -HALF_TURN)
				dh += FULL_TURN;
			a = (blend >= 17'd65536) ? 64'sd0 : longint'(blend);
			vx = lowpass_mix(last_vel_x,
				finite_rate(longint'(px) - longint'(last_x), gap), a);
			vy = lowpass_mix(last_vel_y,
				finite_rate(longint'(py) - longint'(last_y), gap), a);
			wz = lowpass_mix(last_yaw_rate, finite_rate(dh, gap), a);
		end else begin
			primed = 1'b1;
		end
		last_x        = px;
		last_y        = py;
		last_heading  = ph;
		last_vel_x    = vx;
		last_vel_y    = vy;
		last_yaw_rate = wz;
		last_stamp    = 64'(st);
		est.x         = px;
		est.y         = py;
		est.heading   = ph;
		est.vel_x     = vx;
		est.vel_y     = vy;
		est.yaw_rate  = wz;
		pending_estimates.push_back(est);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
	endtask

	// compare one result with the oldest owed estimate
	task check_estimate(logic [pvle_pkg::OUT_DATA_W-1:0] d);
		pose_estimate_t want;
		if (pending_estimates.size() == 0) begin
			report("result with no estimate pending", d[31:0], 32'd0);
			return;
		end
		want = pending_estimates.pop_front();
		if (d[31:0] !== want.x)
			report("out_x", d[31:0], want.x);
		if (d[63:32] !== want.y)
			report("out_y", d[63:32], want.y);
		if (d[82:64] !== want.heading)
			report("out_heading", 32'(d[82:64]), 32'(want.heading));
		if (d[114:83] !== want.vel_x)
			report("vel_x", d[114:83], want.vel_x);
		if (d[146:115] !== want.vel_y)
			report("vel_y", d[146:115], want.vel_y);
		if (d[178:147] !== want.yaw_rate)
			report("yaw_rate", d[178:147], want.yaw_rate);
	endtask
endclass

module tb_pose_velocity_lowpass_estimator_core;
	import pvle_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int PHASE_ITEMS    = 305;
	localparam int DRAIN_PAUSE    = 200;
	localparam int END_PAUSE      = 300;
	localparam logic [62:0] STAMP_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pose_rate_tracker tracker = new();
	bit               quiet_run = 1'b0;
	int               hold_cycles = 0;
	int               stuck_cycles = 0;

	pose_velocity_lowpass_estimator_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the result side unless in a quiet run: short random drops plus rare long holds
	always @(posedge clk) begin
		if (quiet_run) begin
			m_axis_tready <= 1'b1;
		end else if (hold_cycles != 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if ($urandom_range(0, 4999) == 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= $urandom_range(50, 300);
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= 4);
		end
	end

	// Check every result request that is taken
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_estimate(m_axis_tdata);
	end

	// Abort when no request moves on any channel for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	function automatic longint unsigned rand64();
		return {$urandom, $urandom};
	endfunction

	// Offer one pose, hold it until taken, then maybe idle
	task automatic send_pose(input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [18:0] ph, input logic [62:0] st);
		s_axis_tdata  <= {6'd0, st, ph, py, px};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_pose(px, py, ph, st);
		if (!quiet_run && $urandom_range(0, 99) < 10) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 140)) @(posedge clk);
		end
	endtask

	// Drain all owed estimates and let a dropped pose finish, then write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_estimates.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.set_reg(idx, val);
	endtask

	// Mostly plausible motion at legal gaps, some drops, backward and wild poses
	task automatic send_random_pose();
		int unsigned        pick;
		longint unsigned    eff_gap;
		longint unsigned    gap;
		longint unsigned    st;
		bit                 backward;
		int                 hh;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [18:0] ph;
		eff_gap  = (tracker.min_gap == 0) ? 64'd1 : 64'(tracker.min_gap);
		backward = 1'b0;
		gap      = 0;
		pick     = $urandom_range(0, 99);
		if (pick < 55)
			gap = eff_gap + $urandom_range(0, 32'(eff_gap));
		else if (pick < 65)
			gap = eff_gap + $urandom_range(0, 100);
		else if (pick < 70)
			gap = eff_gap;
		else if (pick < 78)
			gap = eff_gap - 1;
		else if (pick < 83)
			gap = $urandom_range(0, 32'(eff_gap - 1));
		else if (pick < 87)
			gap = 0;
		else if (pick < 92)
			backward = 1'b1;
		else if (pick < 98)
			gap = eff_gap + (rand64() & 64'h0000_00FF_FFFF_FFFF);
		else
			gap = eff_gap + (rand64() & 64'h00FF_FFFF_FFFF_FFFF);
		if (backward)
			st = (tracker.last_stamp == 0) ? 64'd0 : rand64() % tracker.last_stamp;
		else
			st = tracker.last_stamp + gap;
		if (st > 64'(STAMP_MAX))
			st = 64'(STAMP_MAX);

		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			px = tracker.last_x + (int'($urandom_range(0, 4000)) - 2000);
			py = tracker.last_y + (int'($urandom_range(0, 4000)) - 2000);
		end else if (pick < 85) begin
			px = tracker.last_x + (int'($urandom_range(0, 2097152)) - 1048576);
			py = tracker.last_y + (int'($urandom_range(0, 2097152)) - 1048576);
		end else begin
			px = $urandom;
			py = $urandom;
		end

		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			hh = tracker.last_heading + int'($urandom_range(0, 20000)) - 10000;
			if (hh > 205887)
				hh -= 411775;
			else if (hh < -205888)
				hh += 411775;
		end else if (pick < 90) begin
			hh = int'($urandom_range(0, 411775)) - 205888;
		end else begin
			hh = $urandom;
		end
		ph = hh[18:0];
		send_pose(px, py, ph, st[62:0]);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First pose at the extremes, then drops (too close, equal, backward) around a pose at exactly the minimum gap
		send_pose(32'h7FFFFFFF, 32'h80000000, 19'sd205887, 63'd0);
		send_pose(32'sd0, 32'sd0, 19'sd0, 63'd4999999);
		send_pose(32'sd1, 32'sd1, 19'sd1, 63'd0);
		send_pose(32'h80000000, 32'h7FFFFFFF, -19'sd205888, 63'd5000000);
		send_pose(32'sd5, 32'sd5, 19'sd5, 63'd4000000);
		send_pose(32'sd6, 32'sd6, 19'sd6, 63'd9999999);
		// Heading wrap both ways, headings outside the half turn
		send_pose(32'h80000000, 32'h7FFFFFFF, 19'sd200000, 63'd10000000);
		send_pose(-32'sd1000, 32'sd1000, -19'sd262144, 63'd15000000);
		send_pose(32'sd2000, -32'sd3000, 19'sd262143, 63'd20000000);
		// Half-count rates round away from zero
		send_pose(32'sd2001, -32'sd3001, 19'sd0, 63'd2020000000);

		// Coefficient out of range, then no filtering at all
		write_reg(REG_BLEND, 32'd65536);
		send_pose(32'sd3000, -32'sd4000, 19'sd1000, 63'(tracker.last_stamp + 5000000));
		write_reg(REG_BLEND, 32'd0);
		send_pose(-32'sd3000, 32'sd4000, -19'sd1000, 63'(tracker.last_stamp + 5000000));

		// Zero minimum acts as one, then the widest minimum
		write_reg(REG_MIN_GAP, 32'd0);
		send_pose(32'sd100000, 32'sd7, 19'sd50, 63'(tracker.last_stamp + 1));
		send_pose(32'sd100001, 32'sd8, 19'sd51, 63'(tracker.last_stamp));
		send_pose(-32'sd100000, 32'sd9, -19'sd50, 63'(tracker.last_stamp + 1));
		write_reg(REG_MIN_GAP, 32'hFFFFFFFF);
		send_pose(32'sd1, 32'sd2, 19'sd3, 63'(tracker.last_stamp + 64'hFFFFFFFE));
		send_pose(32'sd10, 32'sd20, 19'sd30, 63'(tracker.last_stamp + 64'hFFFFFFFF));

		// Back to reset settings; jump the stamp up to set bit 62
		write_reg(REG_MIN_GAP, 32'(MIN_GAP_RESET));
		write_reg(REG_BLEND, 32'(BLEND_RESET));
		send_pose($urandom, $urandom, 19'sd12345, 63'h4000_0000_0000_3039);
		send_pose(32'sd0, 32'sd0, 19'sd0, 63'(tracker.last_stamp + 5000000));
		send_pose(32'h7FFFFFFF, 32'h80000000, 19'sd0, 63'(tracker.last_stamp + 5000000));

		// Random phases, each under its own settings
		for (int phase_idx = 0; phase_idx < 6; phase_idx++) begin
			case (phase_idx)
				0: begin
					write_reg(REG_MIN_GAP, 32'd1);
					write_reg(REG_BLEND, 32'd0);
				end
				1: begin
					write_reg(REG_MIN_GAP, 32'd0);
					write_reg(REG_BLEND, 32'd65535);
				end
				2: begin
					write_reg(REG_MIN_GAP, 32'hFFFFFFFF);
					write_reg(REG_BLEND, 32'd65536);
					quiet_run = 1'b1;
				end
				3: begin
					quiet_run = 1'b0;
					write_reg(REG_MIN_GAP, $urandom_range(1000, 20000000));
					write_reg(REG_BLEND, 32'd131071);
				end
				4: begin
					write_reg(REG_MIN_GAP, 32'(MIN_GAP_RESET));
					write_reg(REG_BLEND, $urandom_range(0, 65535));
				end
				default: begin
					write_reg(REG_MIN_GAP, $urandom_range(1, 50000000));
					write_reg(REG_BLEND, $urandom_range(0, 131071));
				end
			endcase
			repeat (PHASE_ITEMS) send_random_pose();
		end

		// Latest possible stamp, then an equal one that must drop
		send_pose($urandom, $urandom, 19'sd777, STAMP_MAX);
		send_pose($urandom, $urandom, -19'sd777, STAMP_MAX);

		// Drain and let the block settle before the verdict
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_estimates.size() != 0) @(posedge clk);
		repeat (END_PAUSE) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_estimates.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: pose_velocity_lowpass_estimator_core.f
rtl/pvle_pkg.sv
rtl/pvle_div.sv
rtl/pose_velocity_lowpass_estimator_core.sv
bench/tb_pose_velocity_lowpass_estimator_core.sv
